### design/ist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer set table package
// Shared widths, the request codes and the memory access bundle used by the
// set table controller and its value store.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int CAPACITY    = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int OP_W        = 2;
  localparam int VALUE_W     = 32;
  localparam int OCC_W       = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef logic [VALUE_W-1:0] value_t;

  // One access to the value store: a read and a write may share a cycle.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    value_t            wr_data;
  } store_req_t;

endpackage

### design/ist_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer set table value store
// Synchronous memory holding the set's values, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module ist_store (
  input  logic                clk,
  input  ist_pkg::store_req_t req,
  output ist_pkg::value_t     rd_data
);
  import ist_pkg::*;

  value_t mem [CAPACITY];
  value_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/integer_set_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer set table unit
// Set of distinct signed 32-bit values, kept in insertion order, with insert,
// remove, lookup and list requests, held in a synchronous memory with one
// read port and one write port.
// ----------------------------------------------------------------------------
// The unit takes one request transaction at a time and accepts the next as
// soon as its controller is back in idle, even while the previous result
// still waits in the output register. The values sit in one memory with a
// single registered read port, and that port sets the timing. Insert,
// remove and lookup scan the stored entries in order, one entry per cycle,
// comparing until the value is found or all entries have been compared; on
// an empty set they skip the scan and issue the result directly. A remove
// that hits then moves every later entry down by one, one entry per cycle.
// A list request gives one result transaction per entry (read, then load
// the output register), each read waiting until the output register is
// free, or a single result with element_valid low when the set is empty.
// The memory needs no clearing after reset: only entries below the fill
// count are read.
// ----------------------------------------------------------------------------
module integer_set_table_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ist_pkg::IN_TDATA_W-1:0]      in_tdata,  // [31:0] value
  input  logic [ist_pkg::OP_W-1:0]            in_tuser,  // [1:0] op
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] status, [1] present, [7:2] occupancy, [39:8] element
  output logic [ist_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser, // [0] element_valid
  output logic                                out_tlast
);
  import ist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP,
    S_LIST_RD,
    S_LIST_WR
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  value_t            value_r, value_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              wpend_r, wpend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              found_r, found_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_present_r, out_present_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;
  value_t            out_elem_r, out_elem_nxt;
  logic              out_elem_valid_r, out_elem_valid_nxt;
  logic              out_last_r, out_last_nxt;

  store_req_t        st_req;
  value_t            rd_data;
  logic              out_free;
  logic              rd_go;

  ist_store u_store (
    .clk     (clk),
    .req     (st_req),
    .rd_data (rd_data)
  );

  // The output register can take a new result when it is empty or is being
  // drained in this very cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    value_nxt          = value_r;
    cnt_nxt            = cnt_r;
    ptr_nxt            = ptr_r;
    pend_nxt           = pend_r;
    wpend_nxt          = wpend_r;
    wr_addr_nxt        = wr_addr_r;
    found_nxt          = found_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    out_status_nxt     = out_status_r;
    out_present_nxt    = out_present_r;
    out_occ_nxt        = out_occ_r;
    out_elem_nxt       = out_elem_r;
    out_elem_valid_nxt = out_elem_valid_r;
    out_last_nxt       = out_last_r;
    st_req             = '0;
    rd_go              = (ptr_r < cnt_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          value_nxt = in_tdata[VALUE_W-1:0];
          found_nxt = 1'b0;
          ptr_nxt   = '0;
          pend_nxt  = 1'b0;
          wpend_nxt = 1'b0;
          if (cnt_r == '0) begin
            state_nxt = S_RESP;
          end else if (op_t'(in_tuser) == OP_LIST) begin
            state_nxt = S_LIST_RD;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      // Reads stream out one entry per cycle; each compare looks at the data
      // read in the previous cycle, which lives at ptr_r - 1.
      S_SEARCH: begin
        if (pend_r && (rd_data == value_r)) begin
          found_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = (op_r == OP_REMOVE) ? S_SHIFT : S_RESP;
        end else begin
          st_req.rd_en   = rd_go;
          st_req.rd_addr = ptr_r[ADDR_W-1:0];
          pend_nxt       = rd_go;
          if (rd_go) begin
            ptr_nxt = ptr_r + CNT_W'(1);
          end
          if (pend_r && !rd_go) begin
            state_nxt = S_RESP;
          end
        end
      end

      // ptr_r starts one above the hit. Entry j is read in one cycle and
      // written to j - 1 in the next, closing the gap in order.
      S_SHIFT: begin
        st_req.rd_en   = rd_go;
        st_req.rd_addr = ptr_r[ADDR_W-1:0];
        if (wpend_r) begin
          st_req.wr_en   = 1'b1;
          st_req.wr_addr = wr_addr_r;
          st_req.wr_data = rd_data;
        end
        wpend_nxt   = rd_go;
        wr_addr_nxt = ADDR_W'(ptr_r - CNT_W'(1));
        if (rd_go) begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end else if (!wpend_r) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = 1'b0;
          out_present_nxt    = found_r;
          out_elem_nxt       = '0;
          out_elem_valid_nxt = 1'b0;
          out_last_nxt       = 1'b1;
          case (op_r)
            OP_INSERT: begin
              if (!found_r) begin
                if (cnt_r < CNT_W'(CAPACITY)) begin
                  st_req.wr_en   = 1'b1;
                  st_req.wr_addr = cnt_r[ADDR_W-1:0];
                  st_req.wr_data = value_r;
                  cnt_nxt        = cnt_r + CNT_W'(1);
                end else begin
                  out_status_nxt = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (found_r) begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          out_occ_nxt = OCC_W'(cnt_nxt);
          state_nxt   = S_IDLE;
        end
      end

      S_LIST_RD: begin
        if (out_free) begin
          st_req.rd_en   = 1'b1;
          st_req.rd_addr = ptr_r[ADDR_W-1:0];
          state_nxt      = S_LIST_WR;
        end
      end

      // The output register was free when the read was issued and nothing
      // else loads it, so it is empty here.
      S_LIST_WR: begin
        out_valid_nxt      = 1'b1;
        out_status_nxt     = 1'b0;
        out_present_nxt    = 1'b0;
        out_occ_nxt        = OCC_W'(cnt_r);
        out_elem_nxt       = rd_data;
        out_elem_valid_nxt = 1'b1;
        out_last_nxt       = ((ptr_r + CNT_W'(1)) == cnt_r);
        ptr_nxt            = ptr_r + CNT_W'(1);
        state_nxt          = ((ptr_r + CNT_W'(1)) == cnt_r) ? S_IDLE : S_LIST_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    value_r          <= value_nxt;
    ptr_r            <= ptr_nxt;
    wr_addr_r        <= wr_addr_nxt;
    found_r          <= found_nxt;
    out_status_r     <= out_status_nxt;
    out_present_r    <= out_present_nxt;
    out_occ_r        <= out_occ_nxt;
    out_elem_r       <= out_elem_nxt;
    out_elem_valid_r <= out_elem_valid_nxt;
    out_last_r       <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_elem_r, out_occ_r, out_present_r, out_status_r};
  assign out_tuser  = out_elem_valid_r;
  assign out_tlast  = out_last_r;

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // The fill count only moves when a result is issued.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (cnt_r != $past(cnt_r)) |-> $past(state_r) == S_RESP)
    else $error("fill count changed outside result issue");

  // A listed element never overwrites a result still waiting downstream.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST_WR |-> !out_valid_r)
    else $error("list element loaded over a pending result");

  // Memory reads stay below the fill count, so no unwritten entry is used.
  assert property (@(posedge clk) disable iff (!rst_n)
    st_req.rd_en |-> ptr_r < cnt_r)
    else $error("read beyond stored entries");

endmodule
